@@ rtl/core/cvgtr_pkg.sv @@
package cvgtr_pkg;

    localparam int TAPE_DEPTH_DEF = 65536;
    localparam int ENTRY_W        = 32;
    localparam int CFG_ADDR_W     = 4;
    localparam int CFG_DATA_W     = 24;
    localparam int S_TDATA_W      = 64;
    localparam int M_TDATA_W      = 40;

    localparam logic [16:0] Q16_ONE = 17'd65536;

    // register indexes of the configuration channel
    localparam logic [CFG_ADDR_W-1:0] CFG_TRIM_START  = 4'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_TRIM_END    = 4'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_PLAY_SPEED  = 4'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_MODE_SOURCE = 4'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_TRIGGERED   = 4'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_SETTLE      = 4'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_OVF_HOLD    = 4'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_LOOP        = 4'd7;

    typedef enum logic [1:0] {
        TR_STOP = 2'd0,
        TR_PLAY = 2'd1,
        TR_REC  = 2'd2
    } tr_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CTRL,
        S_MTS,
        S_MTE,
        S_MSP,
        S_MLO,
        S_MHI,
        S_RANGE,
        S_READ,
        S_WAIT,
        S_STEP,
        S_MOD,
        S_MODFIN,
        S_OUT
    } state_t;

endpackage

@@ rtl/core/cv_gate_tape_recorder.sv @@
// CV, gate and number tape recorder. One input transaction is one engine tick and gives
// exactly one result transaction. The tape lives in a single synchronous RAM, and each
// tick runs through a sequencer: transport and record write, five passes through
// one shared 17-bit multiplier for the trim and scrub points, range set-up, the tape read
// (read and wait states), the play head step and the output load. When the looping play
// head crosses the region edge, a bit-serial remainder unit runs between the step and
// the output load. A result waiting in the output register does not block the next tick
// from entering. Configuration writes are accepted in any cycle and are meant to be made
// while the block is idle. The tape needs no clearing after reset.
module cv_gate_tape_recorder #(
    parameter int TAPE_DEPTH = cvgtr_pkg::TAPE_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // cv_in[15:0], gates_in[23:16], number_in[31:24], bypass[32], pause[33],
    // scrub[34], scrub_position[51:35], mode_request[53:52], record_button[54],
    // play_button[55], stop_button[56], sample_trigger[57], zero[63:58]
    input  logic [cvgtr_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // cv_out[15:0], gates_out[23:16], number_out[31:24], overflow[32], record_led[33],
    // play_led[34], stop_led[35], leds_driven[36], zero[39:37]
    output logic [cvgtr_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [cvgtr_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [cvgtr_pkg::CFG_DATA_W-1:0] cfg_data
);
    import cvgtr_pkg::*;

    localparam int AW    = $clog2(TAPE_DEPTH);
    localparam int LW    = AW + 1;
    localparam int POS_W = LW + 9;
    localparam int MB_W  = (LW > 17) ? LW : 17;
    localparam int PW    = 17 + MB_W;
    localparam int DW    = POS_W - 1;
    localparam int CNTW  = $clog2(DW + 1);

    localparam logic [LW-1:0] DEPTH_L = LW'(TAPE_DEPTH);

    state_t state_reg, state_next;

    // configuration
    logic [16:0] ts_cfg_reg, ts_cfg_next;
    logic [16:0] te_cfg_reg, te_cfg_next;
    logic [12:0] speed_reg, speed_next;
    logic        msrc_reg, msrc_next;
    logic        trig_mode_reg, trig_mode_next;
    logic [23:0] settle_win_reg, settle_win_next;
    logic [23:0] ovf_hold_reg, ovf_hold_next;
    logic        loop_reg, loop_next;

    // recorder state
    logic [LW-1:0]           len_reg, len_next;
    tr_t                     tr_reg, tr_next;
    logic signed [POS_W-1:0] pos_reg, pos_next;
    logic                    ended_reg, ended_next;
    logic                    rstarted_reg, rstarted_next;
    logic [23:0]             settle_reg, settle_next;
    logic [23:0]             ovf_reg, ovf_next;
    logic [3:0]              prev_reg, prev_next;
    tr_t                     out_state_reg, out_state_next;
    logic                    start_play_reg, start_play_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [CNTW-1:0]         cnt_reg, cnt_next;

    // working payload
    logic [S_TDATA_W-1:0]    in_reg, in_next;
    logic [LW+15:0]          pts_reg, pts_next;
    logic [LW+15:0]          pte_reg, pte_next;
    logic [33:0]             pdiff_reg, pdiff_next;
    logic [LW+15:0]          acc_reg, acc_next;
    logic [LW+16:0]          phi_reg, phi_next;
    logic signed [POS_W-1:0] rs8_reg, rs8_next;
    logic signed [POS_W-1:0] re8_reg, re8_next;
    logic [LW-1:0]           lo_reg, lo_next;
    logic [LW-1:0]           hi_reg, hi_next;
    logic [LW-1:0]           sidx_reg, sidx_next;
    logic [ENTRY_W-1:0]      tape_reg, tape_next;
    logic [POS_W-1:0]        rem_reg, rem_next;
    logic [DW-1:0]           div_reg, div_next;
    logic                    bwd_reg, bwd_next;
    logic [M_TDATA_W-1:0]    m_tdata_reg, m_tdata_next;

    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [ENTRY_W-1:0] rd_data;

    // input fields
    logic [15:0] f_cv;
    logic [7:0]  f_gates;
    logic [7:0]  f_num;
    logic        f_bypass, f_pause, f_scrub;
    logic [16:0] f_spos;
    logic [1:0]  f_req;
    logic        f_rec, f_play, f_stop, f_trig;

    assign f_cv     = in_reg[15:0];
    assign f_gates  = in_reg[23:16];
    assign f_num    = in_reg[31:24];
    assign f_bypass = in_reg[32];
    assign f_pause  = in_reg[33];
    assign f_scrub  = in_reg[34];
    assign f_spos   = in_reg[51:35];
    assign f_req    = in_reg[53:52];
    assign f_rec    = in_reg[54];
    assign f_play   = in_reg[55];
    assign f_stop   = in_reg[56];
    assign f_trig   = in_reg[57];

    // saturated trim points
    logic [16:0] ts_sat, te_lim, te_sat, te_ts, spos_sat;
    logic signed [POS_W-1:0] speed_s;
    logic [POS_W-1:0] reg_len;

    assign ts_sat   = (ts_cfg_reg > Q16_ONE) ? Q16_ONE : ts_cfg_reg;
    assign te_lim   = (te_cfg_reg > Q16_ONE) ? Q16_ONE : te_cfg_reg;
    assign te_sat   = (te_lim < ts_sat) ? ts_sat : te_lim;
    assign te_ts    = te_sat - ts_sat;
    assign spos_sat = (f_spos > Q16_ONE) ? Q16_ONE : f_spos;
    assign speed_s  = POS_W'($signed(speed_reg));
    assign reg_len  = POS_W'(re8_reg - rs8_reg);

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign rd_en     = (state_reg == S_READ);

    always_comb begin
        logic [16:0]             mul_a;
        logic [MB_W-1:0]         mul_b;
        logic [PW-1:0]           mul_p;
        logic [23:0]             sr_d;
        tr_t                     tr_c;
        logic                    start_rec;
        logic [2:0]              lv, rise;
        logic [LW-1:0]           len_c;
        logic                    edge_t;
        logic                    do_append;
        logic [LW+16:0]          tmp_r;
        logic [LW+16:0]          tmp_e;
        logic [LW:0]             ceil_e;
        logic [LW-1:0]           lo_c, hi_c, lmax;
        logic [LW+16:0]          total;
        logic signed [POS_W-1:0] pe, idx, lo_s, hi_s;
        logic signed [POS_W-1:0] np;
        logic                    past;
        logic [POS_W-1:0]        rem_s;
        logic [POS_W-1:0]        rem_fix;

        state_next      = state_reg;
        ts_cfg_next     = ts_cfg_reg;
        te_cfg_next     = te_cfg_reg;
        speed_next      = speed_reg;
        msrc_next       = msrc_reg;
        trig_mode_next  = trig_mode_reg;
        settle_win_next = settle_win_reg;
        ovf_hold_next   = ovf_hold_reg;
        loop_next       = loop_reg;
        len_next        = len_reg;
        tr_next         = tr_reg;
        pos_next        = pos_reg;
        ended_next      = ended_reg;
        rstarted_next   = rstarted_reg;
        settle_next     = settle_reg;
        ovf_next        = ovf_reg;
        prev_next       = prev_reg;
        out_state_next  = out_state_reg;
        start_play_next = start_play_reg;
        m_tvalid_next   = m_tvalid_reg;
        cnt_next        = cnt_reg;
        in_next         = in_reg;
        pts_next        = pts_reg;
        pte_next        = pte_reg;
        pdiff_next      = pdiff_reg;
        acc_next        = acc_reg;
        phi_next        = phi_reg;
        rs8_next        = rs8_reg;
        re8_next        = re8_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        sidx_next       = sidx_reg;
        tape_next       = tape_reg;
        rem_next        = rem_reg;
        div_next        = div_reg;
        bwd_next        = bwd_reg;
        m_tdata_next    = m_tdata_reg;

        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = {f_num, f_gates, f_cv};
        rd_addr = '0;

        mul_a = '0;
        mul_b = '0;
        sr_d = '0; tr_c = tr_reg; start_rec = 1'b0; lv = '0; rise = '0;
        len_c = len_reg; edge_t = 1'b0; do_append = 1'b0;
        tmp_r = '0; tmp_e = '0; ceil_e = '0; lo_c = '0; hi_c = '0; lmax = '0;
        total = '0; pe = '0; idx = '0; lo_s = '0; hi_s = '0; np = '0; past = 1'b0;
        rem_s = '0; rem_fix = '0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        if (cfg_valid) begin
            case (cfg_addr)
                CFG_TRIM_START:  ts_cfg_next     = cfg_data[16:0];
                CFG_TRIM_END:    te_cfg_next     = cfg_data[16:0];
                CFG_PLAY_SPEED:  speed_next      = cfg_data[12:0];
                CFG_MODE_SOURCE: msrc_next       = cfg_data[0];
                CFG_TRIGGERED:   trig_mode_next  = cfg_data[0];
                CFG_SETTLE:      settle_win_next = cfg_data;
                CFG_OVF_HOLD:    ovf_hold_next   = cfg_data;
                CFG_LOOP:        loop_next       = cfg_data[0];
                default: ;
            endcase
        end

        // shared multiplier operands
        case (state_reg)
            S_MTS: begin
                mul_a = ts_sat;
                mul_b = MB_W'(len_reg);
            end
            S_MTE: begin
                mul_a = te_sat;
                mul_b = MB_W'(len_reg);
            end
            S_MSP: begin
                mul_a = spos_sat;
                mul_b = MB_W'(te_ts);
            end
            S_MLO: begin
                mul_a = {1'b0, pdiff_reg[15:0]};
                mul_b = MB_W'(len_reg);
            end
            S_MHI: begin
                mul_a = 17'(ts_sat + pdiff_reg[32:16]);
                mul_b = MB_W'(len_reg);
            end
            default: ;
        endcase
        mul_p = PW'(mul_a) * PW'(mul_b);

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    in_next    = s_tdata;
                    state_next = S_CTRL;
                end
            end

            S_CTRL: begin
                sr_d     = (settle_reg != '0) ? settle_reg - 24'd1 : '0;
                ovf_next = (ovf_reg != '0) ? ovf_reg - 24'd1 : '0;
                start_play_next = 1'b0;
                if (msrc_reg) begin
                    tr_c = (f_req == 2'd3) ? TR_REC : tr_t'(f_req);
                    start_rec       = (tr_c == TR_REC) && (tr_reg != TR_REC);
                    start_play_next = (tr_c == TR_PLAY) && (tr_reg != TR_PLAY);
                end else begin
                    lv   = {f_stop, f_play, f_rec};
                    rise = lv & ~prev_reg[2:0];
                    prev_next[2:0] = lv;
                    if (rise[2]) begin
                        tr_c = TR_STOP;
                    end
                    if (rise[0]) begin
                        if (tr_c == TR_REC) begin
                            tr_c = TR_STOP;
                        end else begin
                            tr_c      = TR_REC;
                            start_rec = 1'b1;
                        end
                    end
                    if (rise[1]) begin
                        tr_c            = TR_PLAY;
                        start_play_next = 1'b1;
                    end
                end
                tr_next        = tr_c;
                out_state_next = tr_c;
                settle_next    = sr_d;
                if (start_rec) begin
                    len_c         = '0;
                    rstarted_next = 1'b0;
                    settle_next   = '0;
                end
                if (tr_c == TR_REC && !f_pause && !f_scrub) begin
                    if (trig_mode_reg) begin
                        edge_t       = f_trig && !prev_reg[3];
                        prev_next[3] = f_trig;
                        if (edge_t) begin
                            do_append     = 1'b1;
                            rstarted_next = 1'b1;
                            settle_next   = settle_win_reg;
                        end else if (rstarted_next && settle_next != '0 && len_c != '0) begin
                            // settle window: keep refreshing the newest entry
                            wr_en   = 1'b1;
                            wr_addr = AW'(len_c - 1'b1);
                        end
                    end else begin
                        do_append = 1'b1;
                    end
                end
                if (do_append) begin
                    if (len_c < DEPTH_L) begin
                        wr_en   = 1'b1;
                        wr_addr = AW'(len_c);
                        len_c   = len_c + 1'b1;
                    end else begin
                        ovf_next = ovf_hold_reg;
                    end
                end
                len_next   = len_c;
                state_next = S_MTS;
            end

            S_MTS: begin
                pts_next   = mul_p[LW+15:0];
                state_next = S_MTE;
            end

            S_MTE: begin
                pte_next   = mul_p[LW+15:0];
                state_next = S_MSP;
            end

            S_MSP: begin
                pdiff_next = mul_p[33:0];
                state_next = S_MLO;
            end

            S_MLO: begin
                acc_next   = mul_p[LW+15:0];
                state_next = S_MHI;
            end

            S_MHI: begin
                phi_next   = (LW+17)'(mul_p);
                state_next = S_RANGE;
            end

            S_RANGE: begin
                tmp_r    = (LW+17)'(pts_reg) + (LW+17)'(255);
                tmp_e    = (LW+17)'(pte_reg) + (LW+17)'(255);
                rs8_next = $signed(POS_W'(tmp_r >> 8));
                re8_next = $signed(POS_W'(tmp_e >> 8));
                lo_c     = LW'(pts_reg >> 16);
                tmp_e    = (LW+17)'(pte_reg) + (LW+17)'(65535);
                ceil_e   = (LW+1)'(tmp_e >> 16);
                hi_c     = (ceil_e == '0) ? '0 : LW'(ceil_e - 1'b1);
                if (len_reg != '0) begin
                    lmax = len_reg - 1'b1;
                    if (lo_c > lmax) lo_c = lmax;
                    if (hi_c > lmax) hi_c = lmax;
                end
                if (hi_c < lo_c) hi_c = lo_c;
                lo_next    = lo_c;
                hi_next    = hi_c;
                total      = phi_reg + (LW+17)'(acc_reg >> 16);
                sidx_next  = LW'(total >> 16);
                state_next = S_READ;
            end

            S_READ: begin
                pe = pos_reg;
                if (start_play_reg) begin
                    pe         = speed_s[POS_W-1] ? re8_reg - 1'b1 : rs8_reg;
                    ended_next = 1'b0;
                end
                pos_next = pe;
                lo_s = $signed(POS_W'(lo_reg));
                hi_s = $signed(POS_W'(hi_reg));
                if (f_scrub) begin
                    idx = $signed(POS_W'(sidx_reg));
                end else if (pe < 0) begin
                    idx = lo_s;
                end else begin
                    idx = pe >>> 8;
                end
                if (idx < lo_s) idx = lo_s;
                if (idx > hi_s) idx = hi_s;
                rd_addr    = idx[AW-1:0];
                state_next = S_WAIT;
            end

            S_WAIT: begin
                tape_next  = (len_reg != '0) ? rd_data : '0;
                state_next = S_STEP;
            end

            S_STEP: begin
                state_next = S_OUT;
                if (out_state_reg == TR_PLAY && !f_scrub && !f_pause && !ended_reg
                    && len_reg != '0) begin
                    np   = pos_reg + speed_s;
                    past = speed_s[POS_W-1] ? (np < rs8_reg) : (np >= re8_reg);
                    pos_next = np;
                    if (past) begin
                        if (loop_reg && re8_reg > rs8_reg) begin
                            // wrap through the serial remainder unit
                            bwd_next   = (np < re8_reg);
                            div_next   = (np >= re8_reg) ? DW'(np - rs8_reg)
                                                         : DW'(rs8_reg - np);
                            rem_next   = '0;
                            cnt_next   = CNTW'(DW);
                            state_next = S_MOD;
                        end else if (msrc_reg) begin
                            ended_next = 1'b1;
                            pos_next   = $signed(POS_W'(speed_s[POS_W-1] ? {lo_reg, 8'd0}
                                                                         : {hi_reg, 8'd0}));
                        end else begin
                            tr_next = TR_STOP;
                        end
                    end
                end
            end

            S_MOD: begin
                rem_s = {rem_reg[POS_W-2:0], div_reg[DW-1]};
                if (rem_s >= reg_len) rem_s = rem_s - reg_len;
                rem_next = rem_s;
                div_next = {div_reg[DW-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1)) begin
                    state_next = S_MODFIN;
                end
            end

            S_MODFIN: begin
                rem_fix = rem_reg;
                if (bwd_reg && rem_reg != '0) begin
                    rem_fix = reg_len - rem_reg;
                end
                pos_next   = rs8_reg + $signed(rem_fix);
                state_next = S_OUT;
            end

            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tdata_next = '0;
                    if (!f_bypass && (f_scrub || out_state_reg == TR_PLAY)) begin
                        m_tdata_next[31:0] = tape_reg;
                    end else begin
                        m_tdata_next[31:0] = {f_num, f_gates, f_cv};
                    end
                    m_tdata_next[32] = (ovf_reg != '0);
                    if (!msrc_reg) begin
                        m_tdata_next[33] = !f_scrub && out_state_reg == TR_REC;
                        m_tdata_next[34] = f_scrub || out_state_reg == TR_PLAY;
                        m_tdata_next[35] = !f_scrub && out_state_reg == TR_STOP;
                        m_tdata_next[36] = 1'b1;
                    end
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            ts_cfg_reg     <= '0;
            te_cfg_reg     <= Q16_ONE;
            speed_reg      <= 13'd256;
            msrc_reg       <= 1'b0;
            trig_mode_reg  <= 1'b0;
            settle_win_reg <= '0;
            ovf_hold_reg   <= 24'd500;
            loop_reg       <= 1'b0;
            len_reg        <= '0;
            tr_reg         <= TR_STOP;
            pos_reg        <= '0;
            ended_reg      <= 1'b0;
            rstarted_reg   <= 1'b0;
            settle_reg     <= '0;
            ovf_reg        <= '0;
            prev_reg       <= '0;
            out_state_reg  <= TR_STOP;
            start_play_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            cnt_reg        <= '0;
        end else begin
            state_reg      <= state_next;
            ts_cfg_reg     <= ts_cfg_next;
            te_cfg_reg     <= te_cfg_next;
            speed_reg      <= speed_next;
            msrc_reg       <= msrc_next;
            trig_mode_reg  <= trig_mode_next;
            settle_win_reg <= settle_win_next;
            ovf_hold_reg   <= ovf_hold_next;
            loop_reg       <= loop_next;
            len_reg        <= len_next;
            tr_reg         <= tr_next;
            pos_reg        <= pos_next;
            ended_reg      <= ended_next;
            rstarted_reg   <= rstarted_next;
            settle_reg     <= settle_next;
            ovf_reg        <= ovf_next;
            prev_reg       <= prev_next;
            out_state_reg  <= out_state_next;
            start_play_reg <= start_play_next;
            m_tvalid_reg   <= m_tvalid_next;
            cnt_reg        <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_reg      <= in_next;
        pts_reg     <= pts_next;
        pte_reg     <= pte_next;
        pdiff_reg   <= pdiff_next;
        acc_reg     <= acc_next;
        phi_reg     <= phi_next;
        rs8_reg     <= rs8_next;
        re8_reg     <= re8_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        sidx_reg    <= sidx_next;
        tape_reg    <= tape_next;
        rem_reg     <= rem_next;
        div_reg     <= div_next;
        bwd_reg     <= bwd_next;
        m_tdata_reg <= m_tdata_next;
    end

    cvgtr_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TAPE_DEPTH)
    ) u_tape (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

`ifndef NO_ASSERTIONS
    a_write_only_in_ctrl: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> state_reg == S_CTRL)
        else $error("tape written outside the transport step");

    a_accept_starts_ctrl: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> state_reg == S_CTRL)
        else $error("accepted transaction did not start processing");

    a_length_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= DEPTH_L)
        else $error("record length beyond tape depth");

    a_rem_below_len: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_MOD |-> rem_reg < reg_len)
        else $error("remainder not below region length");
`endif

endmodule

@@ rtl/core/cvgtr_ram.sv @@
module cvgtr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ verif/cv_gate_tape_recorder_test.sv @@
`default_nettype none

module cv_gate_tape_recorder_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cvgtr_pkg::*;

    localparam int unsigned DEPTH      = 256;
    localparam int          IDLE_LIMIT = 3000;
    localparam int          DRAIN_WAIT = 60;

    typedef struct {
        logic [15:0] cv;
        logic [7:0]  gates;
        logic [7:0]  num;
        logic        bypass;
        logic        pause;
        logic        scrub;
        logic [16:0] scrub_pos;
        logic [1:0]  req;
        logic        rec_btn;
        logic        play_btn;
        logic        stop_btn;
        logic        trig;
    } tick_t;

    typedef struct {
        logic [15:0] cv;
        logic [7:0]  gates;
        logic [7:0]  num;
        logic        ovf;
        logic        rec_led;
        logic        play_led;
        logic        stop_led;
        logic        leds_on;
    } deck_out_t;

    class tape_scoreboard;
        int unsigned depth;
        logic [16:0] trim_s, trim_e;
        logic [12:0] speed_r;
        bit          msrc, trig_mode, loop_en;
        logic [23:0] settle_w, ovf_hold;
        logic [31:0] tape[];
        int unsigned rec_len;
        tr_t         tport;
        longint      pos;
        bit          ended, started;
        int unsigned settle_left, ovf_left;
        bit [3:0]    prev;
        deck_out_t   pending[$];
        int          errors;

        function new(int unsigned d);
            depth = d;
            tape = new[d];
            foreach (tape[i]) tape[i] = '0;
            trim_s = 17'd0; trim_e = 17'd65536; speed_r = 13'd256;
            msrc = 0; trig_mode = 0; loop_en = 0;
            settle_w = 24'd0; ovf_hold = 24'd500;
            rec_len = 0; tport = TR_STOP; pos = 0; ended = 0; started = 0;
            settle_left = 0; ovf_left = 0; prev = '0; errors = 0;
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] a, logic [CFG_DATA_W-1:0] v);
            case (a)
                CFG_TRIM_START:  trim_s    = v[16:0];
                CFG_TRIM_END:    trim_e    = v[16:0];
                CFG_PLAY_SPEED:  speed_r   = v[12:0];
                CFG_MODE_SOURCE: msrc      = v[0];
                CFG_TRIGGERED:   trig_mode = v[0];
                CFG_SETTLE:      settle_w  = v;
                CFG_OVF_HOLD:    ovf_hold  = v;
                CFG_LOOP:        loop_en   = v[0];
                default: ;
            endcase
        endfunction

        function longint sat16(longint v);
            return v > 65536 ? 65536 : v;
        endfunction

        function void append(logic [31:0] e);
            if (rec_len < depth) begin
                tape[rec_len] = e;
                rec_len++;
            end else begin
                ovf_left = 32'(ovf_hold);
            end
        endfunction

        function void note_tick(tick_t t);
            longint    spd, L, ts, te, rs8, re8, lo, hi, idx, len, d, p;
            bit        srec, splay, trig_rise;
            tr_t       ns, out_st;
            bit [2:0]  lv, rise;
            logic [31:0] e, tape_e;
            deck_out_t r;
            spd = longint'($signed(speed_r));
            srec = 0; splay = 0;
            if (settle_left > 0) settle_left--;
            if (ovf_left > 0) ovf_left--;

            if (msrc) begin
                ns = (t.req == 2'd3) ? TR_REC : tr_t'(t.req);
                if (ns == TR_REC && tport != TR_REC) srec = 1;
                if (ns == TR_PLAY && tport != TR_PLAY) splay = 1;
                tport = ns;
            end else begin
                lv = {t.stop_btn, t.play_btn, t.rec_btn};
                rise = lv & ~prev[2:0];
                prev[2:0] = lv;
                if (rise[2]) tport = TR_STOP;
                if (rise[0]) begin
                    if (tport == TR_REC) tport = TR_STOP;
                    else begin
                        tport = TR_REC;
                        srec = 1;
                    end
                end
                if (rise[1]) begin
                    tport = TR_PLAY;
                    splay = 1;
                end
            end
            out_st = tport;

            if (srec) begin
                rec_len = 0; started = 0; settle_left = 0;
            end

            if (tport == TR_REC && !t.pause && !t.scrub) begin
                e = {t.num, t.gates, t.cv};
                if (trig_mode) begin
                    trig_rise = t.trig && !prev[3];
                    prev[3] = t.trig;
                    if (trig_rise) begin
                        append(e);
                        started = 1;
                        settle_left = 32'(settle_w);
                    end else if (started && settle_left > 0 && rec_len > 0) begin
                        tape[(rec_len - 1) % depth] = e;
                    end
                end else begin
                    append(e);
                end
            end

            L = longint'(rec_len);
            ts = sat16(longint'(trim_s));
            te = sat16(longint'(trim_e));
            if (te < ts) te = ts;
            rs8 = (ts * L + 255) >>> 8;
            re8 = (te * L + 255) >>> 8;
            lo = (ts * L) >>> 16;
            hi = ((te * L + 65535) >>> 16) - 1;
            if (L > 0) begin
                if (lo > L - 1) lo = L - 1;
                if (hi > L - 1) hi = L - 1;
            end
            if (hi < lo) hi = lo;

            if (splay) begin
                pos = spd >= 0 ? rs8 : re8 - 1;
                ended = 0;
            end

            tape_e = '0;
            if (L > 0) begin
                if (t.scrub) begin
                    p = (ts << 16) + sat16(longint'(t.scrub_pos)) * (te - ts);
                    idx = (L * p) >>> 32;
                end else begin
                    idx = pos < 0 ? lo : (pos >>> 8);
                end
                if (idx < lo) idx = lo;
                if (idx > hi) idx = hi;
                tape_e = tape[idx % depth];
            end

            if (out_st == TR_PLAY && !t.scrub && !t.pause && !ended && L > 0) begin
                pos += spd;
                if (spd >= 0 ? (pos >= re8) : (pos < rs8)) begin
                    len = re8 - rs8;
                    if (loop_en && len > 0) begin
                        if (pos >= re8) begin
                            pos = rs8 + (pos - rs8) % len;
                        end else if (pos < rs8) begin
                            d = (rs8 - pos) % len;
                            pos = rs8 + (d == 0 ? 0 : len - d);
                        end
                    end else if (msrc) begin
                        ended = 1;
                        pos = (spd >= 0 ? hi : lo) * 256;
                    end else begin
                        tport = TR_STOP;
                    end
                end
            end

            if (!t.bypass && (t.scrub || out_st == TR_PLAY)) begin
                r.cv = tape_e[15:0]; r.gates = tape_e[23:16]; r.num = tape_e[31:24];
            end else begin
                r.cv = t.cv; r.gates = t.gates; r.num = t.num;
            end
            r.ovf = ovf_left > 0;
            r.rec_led  = !msrc && !t.scrub && out_st == TR_REC;
            r.play_led = !msrc && (t.scrub || out_st == TR_PLAY);
            r.stop_led = !msrc && !t.scrub && out_st == TR_STOP;
            r.leds_on  = !msrc;
            pending.push_back(r);
        endfunction

        function void mismatch(string what, longint exp_v, longint got_v);
            $display("%0t %s mismatch: expected %0h actual %0h", $realtime, what, exp_v, got_v);
            errors++;
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] d);
            deck_out_t x;
            if (pending.size() == 0) begin
                $display("%0t unexpected result transaction: expected none actual %0h",
                         $realtime, d);
                errors++;
                return;
            end
            x = pending.pop_front();
            if (d[15:0] !== x.cv)
                mismatch("cv_out", longint'(x.cv), longint'(d[15:0]));
            if (d[23:16] !== x.gates)
                mismatch("gates_out", longint'(x.gates), longint'(d[23:16]));
            if (d[31:24] !== x.num)
                mismatch("number_out", longint'(x.num), longint'(d[31:24]));
            if (d[32] !== x.ovf)
                mismatch("overflow", longint'(x.ovf), longint'(d[32]));
            if (d[33] !== x.rec_led)
                mismatch("record_led", longint'(x.rec_led), longint'(d[33]));
            if (d[34] !== x.play_led)
                mismatch("play_led", longint'(x.play_led), longint'(d[34]));
            if (d[35] !== x.stop_led)
                mismatch("stop_led", longint'(x.stop_led), longint'(d[35]));
            if (d[36] !== x.leds_on)
                mismatch("leds_driven", longint'(x.leds_on), longint'(d[36]));
            if (d[39:37] !== 3'd0)
                mismatch("padding", '0, longint'(d[39:37]));
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    tape_scoreboard deck_sb;
    bit no_idle = 0;
    int idle_cycles = 0;
    int stall_left = 0;

    cv_gate_tape_recorder #(.TAPE_DEPTH(DEPTH)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_addr(cfg_addr), .cfg_data(cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 70) return 0;
        if (k < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side and watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) deck_sb.check_result(m_tdata);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t watchdog: no transaction for %0d cycles", $realtime, IDLE_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready = 1'b0;
        end else if (stall_left > 0) begin
            m_tready = 1'b0;
            stall_left--;
        end else begin
            m_tready = 1'b1;
            if (!no_idle && $urandom_range(0, 5) == 0) stall_left = gap_len();
        end
    end

    task automatic write_reg(logic [CFG_ADDR_W-1:0] a, logic [CFG_DATA_W-1:0] v);
        cfg_valid = 1'b1;
        cfg_addr = a;
        cfg_data = v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        deck_sb.write_reg(a, v);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_tick(tick_t t);
        int g;
        s_tvalid = 1'b1;
        s_tdata = {6'd0, t.trig, t.stop_btn, t.play_btn, t.rec_btn, t.req, t.scrub_pos,
                   t.scrub, t.pause, t.bypass, t.num, t.gates, t.cv};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        deck_sb.note_tick(t);
        @(negedge aclk);
        s_tvalid = 1'b0;
        g = no_idle ? 0 : gap_len();
        repeat (g) @(negedge aclk);
    endtask

    task automatic wait_drained();
        while (deck_sb.pending.size() > 0) @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);
    endtask

    function tick_t quiet_tick();
        tick_t t;
        t.cv = 16'($urandom()); t.gates = 8'($urandom()); t.num = 8'($urandom());
        t.bypass = 0; t.pause = 0; t.scrub = 0; t.scrub_pos = '0; t.req = 2'd0;
        t.rec_btn = 0; t.play_btn = 0; t.stop_btn = 0; t.trig = 0;
        return t;
    endfunction

    function logic [CFG_DATA_W-1:0] pick_q16();
        case ($urandom_range(0, 5))
            0: return 24'd0;
            1: return 24'd65536;
            2: return 24'h1FFFF;
            3: return 24'($urandom());
            default: return 24'($urandom_range(0, 65536));
        endcase
    endfunction

    task automatic configure_phase(int ph);
        logic [CFG_DATA_W-1:0] v;
        v = pick_q16();
        write_reg(CFG_TRIM_START, (ph % 3 == 0) ? 24'd0 : v);
        v = pick_q16();
        write_reg(CFG_TRIM_END, (ph % 3 == 0) ? 24'd65536 : v);
        case ($urandom_range(0, 4))
            0: v = 24'h1000;   // most negative
            1: v = 24'h0FFF;   // most positive
            2: v = 24'd0;
            default: v = 24'($urandom());
        endcase
        if (ph % 4 == 1) v = $urandom_range(0, 1) ? 24'd256 : 24'h1F00;
        write_reg(CFG_PLAY_SPEED, v);
        write_reg(CFG_MODE_SOURCE, 24'(ph % 2));
        write_reg(CFG_TRIGGERED, 24'($urandom_range(0, 2) == 0));
        v = 24'($urandom_range(0, 6));
        if (ph == 5) v = 24'hFFFFFF;
        write_reg(CFG_SETTLE, v);
        v = 24'($urandom_range(0, 8));
        if (ph == 3) v = 24'hFFFFFF;
        if (ph == 7) v = 24'd0;
        write_reg(CFG_OVF_HOLD, v);
        write_reg(CFG_LOOP, 24'($urandom_range(0, 1)));
    endtask

    initial begin : run
        tick_t t;
        tr_t intent;
        int ep_left, sent, ph, press;
        deck_sb = new(DEPTH);
        repeat (7) @(negedge aclk);
        aresetn = 1'b1;

        // directed part, first in button mode and then in mode-source mode, otherwise with reset settings
        t = quiet_tick(); t.cv = 16'h7FFF; t.gates = 8'hFF; t.num = 8'hFF; send_tick(t);
        t = quiet_tick(); t.cv = 16'h8000; t.gates = 8'h00; t.num = 8'h00; send_tick(t);
        t = quiet_tick(); t.scrub = 1; t.scrub_pos = 17'h1FFFF; send_tick(t);
        t = quiet_tick(); t.rec_btn = 1; t.cv = 16'h7FFF; send_tick(t);
        t = quiet_tick(); t.cv = 16'h8000; t.gates = 8'hFF; send_tick(t);
        t = quiet_tick(); t.cv = 16'h0000; t.num = 8'hFF; send_tick(t);
        t = quiet_tick(); t.pause = 1; send_tick(t);
        t = quiet_tick(); t.scrub = 1; t.scrub_pos = 17'd65536; send_tick(t);
        t = quiet_tick(); send_tick(t);
        t = quiet_tick(); t.play_btn = 1; send_tick(t);
        t = quiet_tick(); send_tick(t);
        t = quiet_tick(); t.bypass = 1; send_tick(t);
        t = quiet_tick(); t.pause = 1; send_tick(t);
        t = quiet_tick(); t.scrub = 1; t.scrub_pos = 17'd0; send_tick(t);
        t = quiet_tick(); send_tick(t);
        t = quiet_tick(); send_tick(t);
        t = quiet_tick(); t.stop_btn = 1; t.rec_btn = 1; t.play_btn = 1; send_tick(t);
        t = quiet_tick(); t.stop_btn = 1; send_tick(t);
        wait_drained();
        write_reg(CFG_MODE_SOURCE, 24'd1);
        t = quiet_tick(); t.req = 2'd3; send_tick(t);
        t = quiet_tick(); t.req = 2'd3; t.pause = 1; send_tick(t);
        t = quiet_tick(); t.req = 2'd1; send_tick(t);
        t = quiet_tick(); t.req = 2'd1; send_tick(t);
        t = quiet_tick(); t.req = 2'd1; send_tick(t);
        t = quiet_tick(); t.req = 2'd0; send_tick(t);

        sent = 0;
        ph = 0;
        while (sent < 1130) begin
            // every result in before the registers move
            wait_drained();
            no_idle = ($urandom_range(0, 3) == 0);
            configure_phase(ph);
            ep_left = 0;
            intent = TR_STOP;
            press = 0;
            t = quiet_tick();
            for (int n = 0; n < 95 && sent < 1130; n++) begin
                if (ep_left == 0) begin
                    case ($urandom_range(0, 19))
                        0, 1, 2:                 intent = TR_STOP;
                        3, 4, 5, 6, 7, 8, 9, 10: intent = TR_REC;
                        default:                 intent = TR_PLAY;
                    endcase
                    ep_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(8, 50);
                    press = 1;
                end
                ep_left--;
                t.cv = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 16'h7FFF : 16'h8000)
                                                   : 16'($urandom());
                t.gates = 8'($urandom());
                t.num = 8'($urandom());
                t.bypass = ($urandom_range(0, 11) == 0);
                t.pause  = ($urandom_range(0, 11) == 0);
                t.scrub  = ($urandom_range(0, 11) == 0);
                t.scrub_pos = ($urandom_range(0, 5) == 0) ? 17'($urandom())
                                                          : 17'($urandom_range(0, 65536));
                t.req = ($urandom_range(0, 19) == 0) ? 2'($urandom()) : 2'(intent);
                t.rec_btn  = 0;
                t.play_btn = 0;
                t.stop_btn = 0;
                if (press) begin
                    case (intent)
                        TR_REC:  t.rec_btn  = 1;
                        TR_PLAY: t.play_btn = 1;
                        default: t.stop_btn = 1;
                    endcase
                    press = 0;
                end
                if ($urandom_range(0, 19) == 0) t.rec_btn  = ~t.rec_btn;
                if ($urandom_range(0, 19) == 0) t.play_btn = ~t.play_btn;
                if ($urandom_range(0, 19) == 0) t.stop_btn = ~t.stop_btn;
                if ($urandom_range(0, 2) == 0) t.trig = ~t.trig;
                send_tick(t);
                sent++;
            end
            ph++;
        end

        while (deck_sb.pending.size() > 0) @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);
        if (deck_sb.errors == 0 && deck_sb.pending.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
